FILE: rtl/core/tsv_pkg.sv
// Shared types and codes for the touch sequence validator.
// No dependencies; imported by every module of the block.
package tsv_pkg;

	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned TIME_W   = 14;
	localparam int unsigned POS_W    = 14;
	localparam int unsigned DIM_W    = 15;
	localparam int unsigned IDX_W    = 9;
	localparam int unsigned STATUS_W = 3;

	localparam logic [DIM_W-1:0] DIM_RESET = 15'h4000;

	// step kinds
	localparam logic [FUNC_W-1:0] FUNC_DOWN   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_UP     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_END    = 3'd4;

	// verdict codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CANCEL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OWNER    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNCLOSED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EARLIER  = 3'd5;

	typedef enum logic [0:0] {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] screen_width;
		logic [DIM_W-1:0] screen_height;
	} tsv_cfg_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TIME_W-1:0] time_ms;
		logic              finger_sel;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
	} tsv_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    step_index;
		logic                plan_done;
		logic [IDX_W-1:0]    step_count;
		logic [TIME_W-1:0]   duration_ms;
	} tsv_result_t;

endpackage

FILE: rtl/core/tsv_cfg_regs.sv
// Screen size registers written through the plain write port.
// Depends on tsv_pkg.
module tsv_cfg_regs
	import tsv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_reg_t         cfg_addr,
	input  logic [DIM_W-1:0] cfg_wdata,
	output tsv_cfg_t         cfg
);

	tsv_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= DIM_RESET;
			cfg_q.screen_height <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata;
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/tsv_check.sv
// Plan state and per-step verdict logic.
// Depends on tsv_pkg; state advances only on the fire strobe.
module tsv_check
	import tsv_pkg::*;
#(
	parameter int unsigned STEP_LIMIT    = 256,
	parameter int unsigned TIME_LIMIT_MS = 10000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  tsv_item_t   item,
	input  tsv_cfg_t    cfg,
	output tsv_result_t result
);

	localparam int unsigned CNT_W = $clog2(STEP_LIMIT + 1);
	localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(STEP_LIMIT);
	localparam logic [TIME_W-1:0] T_LIMIT   = TIME_W'(TIME_LIMIT_MS);

	logic [TIME_W-1:0] last_time_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        finger_q;
	logic              cancel_q;
	logic              failed_q;

	logic              is_end;
	logic              range_bad;
	logic              cancel_bad;
	logic              owner_bad;
	logic [STATUS_W-1:0] step_status;

	always_comb begin
		is_end = (item.func == FUNC_END);
		range_bad = item.func[2] || (count_q >= CNT_LIMIT) || (item.time_ms > T_LIMIT)
			|| (item.time_ms < last_time_q)
			|| ({1'b0, item.pos_x} >= cfg.screen_width)
			|| ({1'b0, item.pos_y} >= cfg.screen_height);
		cancel_bad = cancel_q && ((item.func != FUNC_CANCEL) || (item.time_ms != last_time_q));
		owner_bad  = ((item.func == FUNC_DOWN) == finger_q[item.finger_sel]);

		priority if (failed_q)   step_status = ST_EARLIER;
		else if (range_bad)      step_status = ST_RANGE;
		else if (cancel_bad)     step_status = ST_CANCEL;
		else if (owner_bad)      step_status = ST_OWNER;
		else                     step_status = ST_OK;

		result.step_index  = IDX_W'(count_q);
		result.plan_done   = is_end;
		result.step_count  = is_end ? IDX_W'(count_q) : '0;
		result.duration_ms = is_end ? last_time_q : '0;
		if (is_end) begin
			priority if (failed_q)                       result.status = ST_EARLIER;
			else if ((count_q == '0) || (|finger_q))     result.status = ST_UNCLOSED;
			else                                         result.status = ST_OK;
		end else begin
			result.status = step_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			count_q     <= '0;
			finger_q    <= '0;
			cancel_q    <= 1'b0;
			failed_q    <= 1'b0;
		end else if (fire) begin
			if (is_end) begin
				last_time_q <= '0;
				count_q     <= '0;
				finger_q    <= '0;
				cancel_q    <= 1'b0;
				failed_q    <= 1'b0;
			end else if (step_status != ST_OK) begin
				failed_q <= 1'b1;
			end else begin
				// accepted step: take ownership, release, or enter cancel phase
				finger_q[item.finger_sel] <= (item.func == FUNC_DOWN) ||
					(item.func == FUNC_MOVE);
				if (item.func == FUNC_CANCEL) begin
					cancel_q <= 1'b1;
				end
				last_time_q <= item.time_ms;
				count_q     <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/touch_sequence_validator_top.sv
// Top level of the touch sequence validator: input register, verdict stage, result register.
// Depends on tsv_pkg, tsv_cfg_regs and tsv_check.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | step word: tuser = func, tdata = time, finger, x, y
//   m_*      | out       | m_tvalid/m_tready  | verdict word, tlast = plan_done
//   cfg_*    | in        | cfg_we             | screen width (index 0) / height (index 1)
//
// One word per cycle sustained while m_tready is high; a step passes through the input register,
// then the result register, before it shows on m_*.
// The plan state in tsv_check updates in the same cycle the step moves into the
// result register, so back-to-back steps see each other's effects.
// arst_n clears both stage valids and all plan state; screen size returns to 16384.
// A stall on m_tready holds the result register, then the input register, then s_tready.
module touch_sequence_validator_top
	import tsv_pkg::*;
#(
	parameter int unsigned STEP_LIMIT    = 256,
	parameter int unsigned TIME_LIMIT_MS = 10000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [47:0]      s_tdata,  // time_ms[13:0], finger_sel[14], pos_x[28:15], pos_y[42:29], zero
	input  logic [2:0]       s_tuser,  // func[2:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,  // status[2:0], step_index[11:3], step_count[20:12],
	                                   // duration_ms[34:21], zero
	output logic             m_tlast,  // plan_done
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [DIM_W-1:0] cfg_wdata
);

	tsv_cfg_t    cfg;
	tsv_item_t   item_s1;
	logic        valid_s1;
	tsv_result_t result;
	tsv_result_t result_s2;
	logic        valid_s2;
	logic        advance;
	logic        take_in;

	tsv_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_reg_t'(cfg_addr)),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// advance stage 1 into the result register when that slot is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register: capture the word, no reset needed
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.func       <= s_tuser;
			item_s1.time_ms    <= s_tdata[13:0];
			item_s1.finger_sel <= s_tdata[14];
			item_s1.pos_x      <= s_tdata[28:15];
			item_s1.pos_y      <= s_tdata[42:29];
		end
	end

	tsv_check #(
		.STEP_LIMIT   (STEP_LIMIT),
		.TIME_LIMIT_MS(TIME_LIMIT_MS)
	) u_check (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (item_s1),
		.cfg   (cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = result_s2.plan_done;
	assign m_tdata  = {5'd0, result_s2.duration_ms, result_s2.step_count,
		result_s2.step_index, result_s2.status};

endmodule

FILE: rtl/core/tsv_checker.sv
// Port-level checks for the touch sequence validator, bound to the top level.
// Depends on tsv_pkg and touch_sequence_validator_top.
module tsv_checker
	import tsv_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// a clean plan close needs at least one accepted step
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && (m_tdata[2:0] == ST_OK) |-> (m_tdata[20:12] != 9'd0))
		else $error("plan closed ok with no steps");

	// count and duration are only reported on the plan close
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[34:12] == 23'd0))
		else $error("count or duration on a non-final word");

	// the unclosed verdict belongs only to the plan close
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[2:0] != ST_UNCLOSED))
		else $error("unclosed verdict on a step word");

endmodule

bind touch_sequence_validator_top tsv_checker u_tsv_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
